FILE: hdl/jcm_pkg.sv
// Package: types, codes and icon patterns for the conveyor mode controller.
package jcm_pkg;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_ARMED    = 2'd1,
    MODE_MANUAL   = 2'd2,
    MODE_CONSTANT = 2'd3
  } mode_t;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_CLICK = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;

  localparam logic [63:0] ICON_INACTIVE = 64'h0000_007E_7E00_0000;
  localparam logic [63:0] ICON_ARMED    = 64'h1818_1818_1800_1818;
  localparam logic [63:0] ICON_FORWARD  = 64'h0010_307E_7E30_1000;
  localparam logic [63:0] ICON_REVERSE  = 64'h0008_0C7E_7E0C_0800;

  // Reciprocal of 100 scaled by 2^22, rounded up.
  localparam logic [15:0] RECIP_100 = 16'd41944;
  localparam logic [6:0]  DEAD_ZONE_RESET = 7'd10;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] joystick_raw;
  } jcm_in_t;

  typedef struct packed {
    logic        drive_forward;
    logic        drive_reverse;
    logic [7:0]  pwm_duty;
    logic        display_write;
    logic [63:0] display_rows;
  } jcm_out_t;

  // Scaled joystick sample with its magnitude and matching duty.
  typedef struct packed {
    logic signed [7:0] joy;
    logic [6:0]        mag;
    logic [7:0]        duty;
  } jcm_joy_t;

  function automatic logic [63:0] icon_rows(mode_t m, logic neg);
    logic [63:0] rows;
    unique case (m)
      MODE_INACTIVE: rows = ICON_INACTIVE;
      MODE_ARMED:    rows = ICON_ARMED;
      default:       rows = neg ? ICON_REVERSE : ICON_FORWARD;
    endcase
    return rows;
  endfunction

endpackage

FILE: hdl/jcm_scale.sv
// Joystick scaling: raw sample to -100..100, magnitude and PWM duty.
module jcm_scale
  import jcm_pkg::*;
(
  input  logic [9:0] raw,
  output jcm_joy_t   joy_o
);

  logic [17:0] prod;
  logic [7:0]  q_est;
  logic [10:0] rem;
  logic [7:0]  q;
  logic signed [7:0] joy;
  logic [6:0]  mag;
  logic [14:0] mag255;
  logic [30:0] duty_prod;

  // raw*200, then floor divide by 1023 via x>>10 plus one correction step
  assign prod   = {1'b0, raw, 7'b0} + {2'b0, raw, 6'b0} + {5'b0, raw, 3'b0};
  assign q_est  = prod[17:10];
  assign rem    = {1'b0, prod[9:0]} + {3'b0, q_est};
  assign q      = q_est + {7'b0, (rem >= 11'd1023)};
  assign joy    = $signed(q - 8'd100);
  assign mag    = joy[7] ? 7'(-joy) : joy[6:0];
  assign mag255 = {mag, 8'b0} - {8'b0, mag};
  assign duty_prod = {16'b0, mag255} * {15'b0, RECIP_100};

  assign joy_o.joy  = joy;
  assign joy_o.mag  = mag;
  assign joy_o.duty = duty_prod[29:22];

endmodule

FILE: hdl/jcm_ctrl.sv
// Mode state machine, motor command state and result register.
module jcm_ctrl
  import jcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_dz,
  input  logic       item_valid,
  input  logic [1:0] item_kind,
  input  jcm_joy_t   item_joy,
  output logic       advance,
  output logic       out_valid,
  input  logic       out_ready,
  output jcm_out_t   out_data
);

  mode_t             mode_r, mode_nxt;
  mode_t             shown_mode_r, shown_mode_nxt;
  logic              shown_neg_r, shown_neg_nxt;
  logic signed [7:0] speed_r, speed_nxt;
  logic [7:0]        duty_r, duty_nxt;
  logic [6:0]        dz_r;
  logic              out_valid_r;
  jcm_out_t          out_r, res;
  logic              centered;
  logic              sign_chg;

  assign advance   = item_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign centered  = (item_joy.mag <= dz_r);

  always_comb begin
    mode_nxt       = mode_r;
    speed_nxt      = speed_r;
    duty_nxt       = duty_r;
    shown_mode_nxt = shown_mode_r;
    shown_neg_nxt  = shown_neg_r;
    sign_chg       = 1'b0;
    res            = '0;
    unique case (item_kind)
      KIND_TICK: begin
        unique case (mode_r)
          MODE_INACTIVE: begin
            speed_nxt = '0;
            duty_nxt  = '0;
          end
          MODE_ARMED: begin
            speed_nxt = '0;
            duty_nxt  = '0;
            if (!centered) mode_nxt = MODE_MANUAL;
          end
          MODE_MANUAL: begin
            if (centered) begin
              speed_nxt = '0;
              duty_nxt  = '0;
              mode_nxt  = MODE_ARMED;
            end else begin
              speed_nxt = item_joy.joy;
              duty_nxt  = item_joy.duty;
            end
          end
          MODE_CONSTANT: begin
          end
          default: begin
          end
        endcase
        sign_chg = ((mode_nxt == MODE_MANUAL) || (mode_nxt == MODE_CONSTANT)) &&
                   (speed_nxt[7] != shown_neg_r);
        if ((mode_nxt != shown_mode_r) || sign_chg) begin
          res.display_write = 1'b1;
          res.display_rows  = icon_rows(mode_nxt, speed_nxt[7]);
          shown_mode_nxt    = mode_nxt;
          shown_neg_nxt     = speed_nxt[7];
        end
      end
      KIND_CLICK: begin
        if (mode_r == MODE_MANUAL) mode_nxt = MODE_CONSTANT;
        else if (mode_r == MODE_CONSTANT) mode_nxt = MODE_MANUAL;
      end
      KIND_LONG: begin
        if (mode_r == MODE_INACTIVE) begin
          mode_nxt = MODE_ARMED;
        end else begin
          speed_nxt = '0;
          duty_nxt  = '0;
          mode_nxt  = MODE_INACTIVE;
        end
      end
      default: begin
      end
    endcase
    res.drive_forward = !speed_nxt[7] && (speed_nxt != 8'sd0);
    res.drive_reverse = speed_nxt[7];
    res.pwm_duty      = duty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_INACTIVE;
      shown_mode_r <= MODE_ARMED;
      shown_neg_r  <= 1'b0;
      speed_r      <= '0;
      duty_r       <= '0;
      dz_r         <= DEAD_ZONE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) dz_r <= cfg_dz;
      if (advance) begin
        mode_r       <= mode_nxt;
        shown_mode_r <= shown_mode_nxt;
        shown_neg_r  <= shown_neg_nxt;
        speed_r      <= speed_nxt;
        duty_r       <= duty_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_r <= res;
  end

endmodule

FILE: hdl/joystick_conveyor_mode_controller.sv
// Conveyor motor mode controller (inactive, armed, manual, constant) driven
// by joystick ticks and button clicks. Each event transfer yields one result
// transfer: H-bridge direction, PWM duty and an optional 8x8 icon rewrite.
// Takes one event per cycle while the result output is not stalled. An input
// transfer reaches the result through joystick scaling ahead of the input
// register, then mode logic ahead of the result register. Dead zone is
// written through the cfg port, always ready, and resets to 10.
module joystick_conveyor_mode_controller
  import jcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  jcm_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output jcm_out_t   out_data
);

  logic       s1_valid_r;
  logic [1:0] s1_kind_r;
  jcm_joy_t   s1_joy_r;
  jcm_joy_t   joy;
  logic       advance;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid_r || advance;

  jcm_scale u_scale (
    .raw   (in_data.joystick_raw),
    .joy_o (joy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_data.kind;
      s1_joy_r  <= joy;
    end
  end

  jcm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_dz     (cfg_data),
    .item_valid (s1_valid_r),
    .item_kind  (s1_kind_r),
    .item_joy   (s1_joy_r),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: tb/tb_joystick_conveyor_mode_controller.sv
// Testbench: checks every conveyor controller report against a behavioral model or directed rows.
module tb_joystick_conveyor_mode_controller;
  import jcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    jcm_in_t  ev;
    bit       typed;
    jcm_out_t want;
  } event_row_t;

  logic     clk;
  logic     rst_n;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [6:0] cfg_data;
  logic     in_valid;
  logic     in_ready;
  jcm_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  jcm_out_t out_data;

  // behavioral copy of the controller state
  mode_t             cv_mode;
  logic signed [7:0] cv_speed;
  logic signed [7:0] cv_cmd;
  mode_t             cv_shown_mode;
  logic signed [7:0] cv_shown_speed;
  logic [6:0]        cv_dead_zone;

  jcm_out_t   expected_reports[$];
  event_row_t directed_rows[$];
  int         mismatches;
  int         in_idle_pct;
  int         out_stall_pct;
  int         stall_left;

  joystick_conveyor_mode_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic jcm_out_t next_motor_report(jcm_in_t ev);
    jcm_out_t r;
    int joy;
    int mag;
    bit centered;
    bit flip;
    r = '0;
    case (ev.kind)
      KIND_TICK: begin
        joy = (int'(ev.joystick_raw) * 200) / 1023 - 100;
        mag = (joy < 0) ? -joy : joy;
        centered = mag <= int'(cv_dead_zone);
        case (cv_mode)
          MODE_INACTIVE: begin
            cv_speed = '0;
            cv_cmd = '0;
          end
          MODE_ARMED: begin
            cv_speed = '0;
            cv_cmd = '0;
            if (!centered) cv_mode = MODE_MANUAL;
          end
          MODE_MANUAL: begin
            if (centered) begin
              cv_speed = '0;
              cv_cmd = '0;
              cv_mode = MODE_ARMED;
            end else begin
              cv_speed = joy[7:0];
              cv_cmd = joy[7:0];
            end
          end
          default: ;
        endcase
        flip = (cv_mode == MODE_MANUAL || cv_mode == MODE_CONSTANT) &&
               ((cv_speed < 0) != (cv_shown_speed < 0));
        if (cv_mode != cv_shown_mode || flip) begin
          r.display_write = 1'b1;
          if (cv_mode == MODE_INACTIVE) r.display_rows = ICON_INACTIVE;
          else if (cv_mode == MODE_ARMED) r.display_rows = ICON_ARMED;
          else if (cv_speed < 0) r.display_rows = ICON_REVERSE;
          else r.display_rows = ICON_FORWARD;
          cv_shown_mode = cv_mode;
          cv_shown_speed = cv_speed;
        end
      end
      KIND_CLICK: begin
        if (cv_mode == MODE_MANUAL) cv_mode = MODE_CONSTANT;
        else if (cv_mode == MODE_CONSTANT) cv_mode = MODE_MANUAL;
      end
      KIND_LONG: begin
        if (cv_mode == MODE_INACTIVE) begin
          cv_mode = MODE_ARMED;
        end else begin
          cv_speed = '0;
          cv_cmd = '0;
          cv_mode = MODE_INACTIVE;
        end
      end
      default: ;
    endcase
    mag = (cv_cmd < 0) ? -int'(cv_cmd) : int'(cv_cmd);
    if (mag > 100) mag = 100;
    r.drive_forward = cv_cmd > 0;
    r.drive_reverse = cv_cmd < 0;
    r.pwm_duty = 8'(mag * 255 / 100);
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    else if (p < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // extremes, samples around the dead-zone rim, or anything
  function automatic logic [9:0] pick_raw();
    int p;
    int v;
    p = $urandom_range(0, 99);
    if (p < 20) begin
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = 1;
        2: v = 511;
        3: v = 512;
        4: v = 1022;
        default: v = 1023;
      endcase
    end else if (p < 50) begin
      v = (int'(cv_dead_zone) * 1023) / 200 + int'($urandom_range(0, 12)) - 6;
      v = $urandom_range(0, 1) ? 512 + v : 512 - v;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
    end else begin
      v = $urandom_range(0, 1023);
    end
    return v[9:0];
  endfunction

  function automatic logic [1:0] pick_kind();
    int p;
    p = $urandom_range(0, 99);
    if (p < 62) return KIND_TICK;
    else if (p < 78) return KIND_CLICK;
    else if (p < 96) return KIND_LONG;
    else return KIND_SPARE;
  endfunction

  task automatic add_row(input logic [1:0] k, input int raw, input bit typed = 0,
                         input logic f = 0, input logic rv = 0,
                         input logic [7:0] duty = 0, input logic wr = 0,
                         input logic [63:0] rows = 0);
    event_row_t row;
    row.ev.kind = k;
    row.ev.joystick_raw = raw[9:0];
    row.typed = typed;
    row.want.drive_forward = f;
    row.want.drive_reverse = rv;
    row.want.pwm_duty = duty;
    row.want.display_write = wr;
    row.want.display_rows = rows;
    directed_rows.push_back(row);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_event(input jcm_in_t ev, input bit typed, input jcm_out_t want);
    int gap;
    jcm_out_t pred;
    gap = ($urandom_range(0, 99) < in_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = ev;
    do @(posedge clk); while (!in_ready);
    pred = next_motor_report(ev);
    expected_reports.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_dead_zone(input logic [6:0] v);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    cv_dead_zone = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    jcm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("drive_forward", want.drive_forward, out_data.drive_forward);
        check_field("drive_reverse", want.drive_reverse, out_data.drive_reverse);
        check_field("pwm_duty", want.pwm_duty, out_data.pwm_duty);
        check_field("display_write", want.display_write, out_data.display_write);
        check_field("display_rows", want.display_rows, out_data.display_rows);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        out_ready = 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int dz_plan[8];
    jcm_in_t ev;
    jcm_out_t none;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    none = '0;
    mismatches = 0;
    in_idle_pct = 20;
    out_stall_pct = 20;
    cv_mode = MODE_INACTIVE;
    cv_speed = '0;
    cv_cmd = '0;
    cv_shown_mode = MODE_ARMED;
    cv_shown_speed = 8'sd1;
    cv_dead_zone = 7'd10;

    add_row(KIND_TICK, 512, 1, 0, 0, 0, 1, ICON_INACTIVE);
    add_row(KIND_CLICK, 0, 1, 0, 0, 0, 0, 0);
    add_row(KIND_SPARE, 1023, 1, 0, 0, 0, 0, 0);
    add_row(KIND_LONG, 0, 1, 0, 0, 0, 0, 0);
    add_row(KIND_TICK, 512, 1, 0, 0, 0, 1, ICON_ARMED);
    add_row(KIND_TICK, 1023);
    add_row(KIND_TICK, 1023, 1, 1, 0, 8'd255, 0, 0);
    add_row(KIND_TICK, 0, 1, 0, 1, 8'd255, 1, ICON_REVERSE);
    add_row(KIND_CLICK, 0);
    add_row(KIND_TICK, 1023);
    add_row(KIND_CLICK, 0);
    add_row(KIND_TICK, 512);
    add_row(KIND_TICK, 563);
    add_row(KIND_TICK, 569);
    add_row(KIND_TICK, 460);
    add_row(KIND_LONG, 0);
    add_row(KIND_TICK, 1023);
    add_row(KIND_LONG, 0);
    add_row(KIND_TICK, 0);
    add_row(KIND_CLICK, 0);
    add_row(KIND_LONG, 0);
    add_row(KIND_LONG, 0);
    add_row(KIND_TICK, 1023);
    add_row(KIND_TICK, 1023);
    add_row(KIND_LONG, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

    dz_plan = '{0, 127, 10, 100, 1, 55, 0, 0};
    dz_plan[6] = $urandom_range(0, 30);
    dz_plan[7] = $urandom_range(0, 127);
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      repeat (3) @(negedge clk);
      write_dead_zone(dz_plan[ph][6:0]);
      if (ph % 3 == 1) begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end else begin
        in_idle_pct = $urandom_range(10, 50);
        out_stall_pct = $urandom_range(10, 50);
      end
      for (int n = 0; n < 82; n++) begin
        ev.kind = pick_kind();
        ev.joystick_raw = (ev.kind == KIND_TICK) ? pick_raw() : 10'($urandom_range(0, 1023));
        send_event(ev, 1'b0, none);
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
